// File: src/wfhq_pkg.sv
// ----------------------------------------------------------------------------
// Watershed flood package
// Shared widths, constants and the command type.
// ----------------------------------------------------------------------------
package wfhq_pkg;

  localparam int unsigned AddrBits  = 16;
  localparam int unsigned LevelBits = 8;
  localparam int unsigned LabelBits = 15;
  localparam int unsigned Levels    = 256;

  localparam logic [LabelBits-1:0] LabelMax = '1;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeFlood = 2'd1,
    ModeRead  = 2'd2,
    ModeNop   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1,
    CfgMax    = 2'd2,
    CfgConn   = 2'd3
  } cfg_e;

  function automatic logic [8:0] eff_dim(input logic [8:0] v);
    if (v < 9'd3) return 9'd3;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

endpackage

// File: src/watershed_flood_hier_queue_top.sv
// ----------------------------------------------------------------------------
// Watershed flood top level
// Seeded watershed by immersion with one linked FIFO per grey level.
// ----------------------------------------------------------------------------
// Commands are taken one at a time; busy stays high from the accepting edge
// through the done_o strobe. A write, a no-op or an out-of-range read goes
// from the accept state straight to the result. A valid read passes through
// the memory access, the shared row/column divider and the frame check before
// the result cycle. A flood runs as long as the image needs: a seed scan and
// a marker clear over the interior pixels, a check of each grey level in
// turn, a queue fetch plus the divider for each queued pixel popped, and per
// neighbour a frame check, then a check for a label or a too-high grey level,
// and a push if it gets queued. The result is shown for exactly one cycle with
// done_o high and cannot be stalled, so the receiver must always take it.
module watershed_flood_hier_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] pixel_index_i,
  input  logic [14:0] seed_label_i,
  input  logic [7:0]  grey_level_i,
  output logic        done_o,
  output logic [14:0] label_value_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  typedef enum logic [15:0] {
    StIdle  = 16'b0000000000000001,
    StAcc   = 16'b0000000000000010,
    StDiv   = 16'b0000000000000100,
    StRdChk = 16'b0000000000001000,
    StScanA = 16'b0000000000010000,
    StScanT = 16'b0000000000100000,
    StNbA   = 16'b0000000001000000,
    StNbC   = 16'b0000000010000000,
    StNbP   = 16'b0000000100000000,
    StClrA  = 16'b0000001000000000,
    StClrW  = 16'b0000010000000000,
    StLvl   = 16'b0000100000000000,
    StPopH  = 16'b0001000000000000,
    StPopL  = 16'b0010000000000000,
    StPopU  = 16'b0100000000000000,
    StDone  = 16'b1000000000000000
  } state_e;

  state_e state_q, state_d;

  logic [8:0] width_q, height_q;
  logic [7:0] maxl_q;
  logic       conn_q;

  // Label (bit 15 = marker), grey and link memories.
  logic [15:0] label_mem [65536];
  logic [7:0]  grey_mem  [65536];
  logic [15:0] link_mem  [65536];
  logic [15:0] head_mem  [256];
  logic [15:0] tail_mem  [256];
  logic [255:0] ne_q;

  logic [1:0]  mode_q;
  logic [15:0] idx_q;
  logic [14:0] seed_q;
  logic [7:0]  grey_q;
  logic [15:0] p_q, q_q;
  logic [7:0]  pr_q, pc_q;
  logic [2:0]  k_q;
  logic        seeding_q;
  logic [7:0]  lvl_q;
  logic [15:0] plab_q;
  logic [15:0] rd_lab_q;
  logic [7:0]  rd_grey_q;
  logic [15:0] rd_link_q;
  logic [15:0] rd_head_q;
  logic [15:0] rd_tail_q;
  logic [16:0] div_rem_q;
  logic [2:0]  div_cnt_q;
  logic [14:0] res_lab_q;
  logic        res_st_q;

  logic [8:0]  w, h;
  logic [16:0] wh;
  logic        idx_bad;
  logic        scan_end;
  logic        scan_step;
  logic        nb_step;
  logic        plab_seed;

  assign w = wfhq_pkg::eff_dim(width_q);
  assign h = wfhq_pkg::eff_dim(height_q);
  assign wh = 17'(w) * 17'(h);
  assign idx_bad = ({1'b0, idx_q} >= wh);
  assign scan_end = ({1'b0, pr_q} + 9'd1 >= h);
  assign plab_seed = (plab_q != 16'd0) && (plab_q < {1'b0, wfhq_pkg::LabelMax});

  assign busy          = (state_q != StIdle);
  // A command and a register write never share an edge.
  assign cfg_ready_o   = (state_q == StIdle) && !start;
  assign done_o        = (state_q == StDone);
  assign label_value_o = res_lab_q;
  assign status_o      = res_st_q;

  // Neighbour offsets for step k (shared neighbour unit).
  logic signed [1:0] dx, dy;
  logic [2:0] nmax;
  always_comb begin
    dx = 2'sd0;
    dy = 2'sd0;
    if (conn_q) begin
      case (k_q)
        3'd0: begin dx = -2'sd1; dy = -2'sd1; end
        3'd1: begin dx =  2'sd0; dy = -2'sd1; end
        3'd2: begin dx =  2'sd1; dy = -2'sd1; end
        3'd3: begin dx = -2'sd1; dy =  2'sd0; end
        3'd4: begin dx =  2'sd1; dy =  2'sd0; end
        3'd5: begin dx = -2'sd1; dy =  2'sd1; end
        3'd6: begin dx =  2'sd0; dy =  2'sd1; end
        default: begin dx = 2'sd1; dy = 2'sd1; end
      endcase
    end else begin
      case (k_q[1:0])
        2'd0: dy = -2'sd1;
        2'd1: dx = -2'sd1;
        2'd2: dx =  2'sd1;
        default: dy = 2'sd1;
      endcase
    end
    nmax = conn_q ? 3'd7 : 3'd3;
  end

  logic [9:0] nr, nc;
  logic       n_in;
  assign nr = {2'b00, pr_q} + {{8{dy[1]}}, dy};
  assign nc = {2'b00, pc_q} + {{8{dx[1]}}, dx};
  assign n_in = (nr != 10'd0) && (nc != 10'd0) && (nr[8:0] < h - 9'd1) &&
                (nc[8:0] < w - 9'd1) && !nr[9] && !nc[9];

  // Shared multiplier: row times width.
  logic [7:0]  mul_r;
  logic [16:0] mul_p;
  logic [15:0] scan_addr, nb_addr;
  assign mul_r = (state_q == StNbA) ? nr[7:0] : pr_q;
  assign mul_p = 17'(mul_r) * 17'(w);
  assign scan_addr = mul_p[15:0] + 16'(pc_q);
  assign nb_addr = mul_p[15:0] + 16'(nc[7:0]);

  logic [7:0] push_lvl;
  assign push_lvl = seeding_q ? rd_grey_q : ((rd_grey_q > lvl_q) ? rd_grey_q : lvl_q);

  // Restoring divider: one quotient bit per cycle, row into pr_q, column last.
  logic [16:0] div_sub;
  logic        div_take;
  logic [16:0] div_rem_next;
  assign div_sub = 17'(w) << div_cnt_q;
  assign div_take = (div_rem_q >= div_sub);
  assign div_rem_next = div_take ? (div_rem_q - div_sub) : div_rem_q;

  always_comb begin
    state_d   = state_q;
    scan_step = 1'b0;
    nb_step   = 1'b0;
    case (state_q)
      StIdle:
        if (start) state_d = StAcc;
      StAcc: begin
        case (mode_q)
          wfhq_pkg::ModeRead:  state_d = idx_bad ? StDone : StDiv;
          wfhq_pkg::ModeFlood: state_d = (wh > 17'd65536) ? StDone : StScanA;
          default:             state_d = StDone;
        endcase
      end
      StDiv:
        if (div_cnt_q == 3'd0) begin
          state_d = (mode_q == wfhq_pkg::ModeRead) ? StRdChk : StNbA;
        end
      StRdChk:
        state_d = StDone;
      StScanA:
        state_d = scan_end ? StClrA : StScanT;
      StScanT:
        if (plab_seed) state_d = StNbA;
        else begin
          scan_step = 1'b1;
          state_d = StScanA;
        end
      StNbA:
        if (n_in) state_d = StNbC;
        else nb_step = 1'b1;
      StNbC:
        if (rd_lab_q != 16'd0 || rd_grey_q > maxl_q) nb_step = 1'b1;
        else state_d = StNbP;
      StNbP:
        nb_step = 1'b1;
      StClrA:
        state_d = scan_end ? StLvl : StClrW;
      StClrW: begin
        scan_step = 1'b1;
        state_d = StClrA;
      end
      StLvl:
        if (ne_q[lvl_q]) state_d = StPopH;
        else if (lvl_q == maxl_q) state_d = StDone;
      StPopH:
        state_d = StPopL;
      StPopL:
        state_d = StPopU;
      StPopU:
        state_d = StDiv;
      StDone:
        state_d = StIdle;
      default:
        state_d = StIdle;
    endcase
    // After the last neighbour, go back to the scan or to the level walk.
    if (nb_step) begin
      if (k_q == nmax) begin
        if (seeding_q) begin
          scan_step = 1'b1;
          state_d = StScanA;
        end else begin
          state_d = StLvl;
        end
      end else begin
        state_d = StNbA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      width_q   <= 9'd256;
      height_q  <= 9'd256;
      maxl_q    <= 8'd255;
      conn_q    <= 1'b0;
      ne_q      <= '0;
      seeding_q <= 1'b1;
      lvl_q     <= 8'd0;
      k_q       <= 3'd0;
      pr_q      <= 8'd1;
      pc_q      <= 8'd1;
      res_lab_q <= '0;
      res_st_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wfhq_pkg::CfgWidth:  width_q  <= cfg_data_i;
          wfhq_pkg::CfgHeight: height_q <= cfg_data_i;
          wfhq_pkg::CfgMax:    maxl_q   <= cfg_data_i[7:0];
          wfhq_pkg::CfgConn:   conn_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (state_q == StAcc && mode_q == wfhq_pkg::ModeFlood) ne_q <= '0;
      else if (state_q == StPopU && p_q == rd_tail_q) ne_q[lvl_q] <= 1'b0;
      else if (state_q == StNbP) ne_q[push_lvl] <= 1'b1;

      if (state_q == StAcc) seeding_q <= 1'b1;
      else if (state_q == StClrA) seeding_q <= 1'b0;

      if (state_q == StAcc) lvl_q <= 8'd0;
      else if (state_q == StLvl && !ne_q[lvl_q] && lvl_q != maxl_q) lvl_q <= lvl_q + 8'd1;

      if (nb_step) k_q <= (k_q == nmax) ? 3'd0 : k_q + 3'd1;

      if (state_q == StIdle || (state_q == StScanA && scan_end)) begin
        pr_q <= 8'd1;
        pc_q <= 8'd1;
      end else if (state_q == StDiv) begin
        pr_q[div_cnt_q] <= div_take;
        if (div_cnt_q == 3'd0) pc_q <= div_rem_next[7:0];
      end else if (scan_step) begin
        if ({1'b0, pc_q} + 9'd2 >= w) begin
          pc_q <= 8'd1;
          pr_q <= pr_q + 8'd1;
        end else begin
          pc_q <= pc_q + 8'd1;
        end
      end

      case (state_q)
        StIdle: begin
          res_lab_q <= '0;
          res_st_q  <= 1'b0;
        end
        StAcc:
          if ((mode_q == wfhq_pkg::ModeWrite || mode_q == wfhq_pkg::ModeRead) && idx_bad)
            res_st_q <= 1'b1;
        StRdChk:
          if (pr_q != 8'd0 && pc_q != 8'd0 && {1'b0, pr_q} != h - 9'd1 &&
              {1'b0, pc_q} != w - 9'd1)
            res_lab_q <= rd_lab_q[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      mode_q <= mode_i;
      idx_q  <= pixel_index_i;
      seed_q <= seed_label_i;
      grey_q <= grey_level_i;
    end
    case (state_q)
      StAcc: begin
        if (mode_q == wfhq_pkg::ModeWrite) begin
          if (!idx_bad) begin
            label_mem[idx_q] <= {1'b0, seed_q};
            grey_mem[idx_q]  <= grey_q;
          end
        end else if (mode_q == wfhq_pkg::ModeRead) begin
          rd_lab_q  <= label_mem[idx_q];
          div_rem_q <= {1'b0, idx_q};
          div_cnt_q <= 3'd7;
        end
      end
      StDiv: begin
        div_rem_q <= div_rem_next;
        div_cnt_q <= div_cnt_q - 3'd1;
      end
      StScanA: begin
        p_q    <= scan_addr;
        plab_q <= label_mem[scan_addr];
      end
      StClrA: begin
        p_q      <= scan_addr;
        rd_lab_q <= label_mem[scan_addr];
      end
      StClrW:
        if (rd_lab_q[15]) label_mem[p_q] <= {1'b0, rd_lab_q[14:0]};
      StNbA: begin
        q_q       <= nb_addr;
        rd_lab_q  <= label_mem[nb_addr];
        rd_grey_q <= grey_mem[nb_addr];
      end
      StNbC: begin
        if (rd_lab_q == 16'd0) begin
          if (rd_grey_q <= maxl_q) begin
            label_mem[q_q] <= seeding_q ? (plab_q | 16'h8000) : plab_q;
            rd_tail_q <= tail_mem[push_lvl];
          end else begin
            label_mem[q_q] <= {1'b0, wfhq_pkg::LabelMax};
          end
        end
      end
      StNbP: begin
        if (ne_q[push_lvl]) link_mem[rd_tail_q] <= q_q;
        else head_mem[push_lvl] <= q_q;
        tail_mem[push_lvl] <= q_q;
      end
      StPopH: begin
        rd_head_q <= head_mem[lvl_q];
        rd_tail_q <= tail_mem[lvl_q];
      end
      StPopL: begin
        p_q       <= rd_head_q;
        rd_link_q <= link_mem[rd_head_q];
        plab_q    <= label_mem[rd_head_q];
      end
      StPopU: begin
        if (p_q != rd_tail_q) head_mem[lvl_q] <= rd_link_q;
        div_rem_q <= {1'b0, p_q};
        div_cnt_q <= 3'd7;
      end
      default: ;
    endcase
  end

endmodule
